// File: sv/sspf_pkg.sv
// Package for the scan sector proximity feedback block.
// Holds payload structs, register indexes, sector bounds, FSM states and the
// command/status structs shared by the controller, the datapath and the top level.
package sspf_pkg;

	localparam int DIST_BITS = 16;
	localparam int ANGLE_BITS = 9;
	localparam int INTENS_BITS = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int SCAN_POINTS = 360;

	localparam logic [INTENS_BITS-1:0] FULL_INTENSITY = '1;
	localparam logic [DIST_BITS-1:0] DIST_ALL_ONES = '1;

	// Restoring division steps: one per quotient bit.
	localparam int DIV_STEPS = INTENS_BITS;
	localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_MIN = 2'd2;

	localparam logic [DIST_BITS-1:0] NEAR_LIMIT_RESET = 16'd500;
	localparam logic [DIST_BITS-1:0] SIDE_LIMIT_RESET = 16'd350;
	localparam logic [DIST_BITS-1:0] RANGE_MIN_RESET = 16'd0;

	// Sector bounds in beam indexes.
	localparam logic [ANGLE_BITS-1:0] FRONT_NARROW_LO = 9'd170;
	localparam logic [ANGLE_BITS-1:0] FRONT_NARROW_HI = 9'd190;
	localparam logic [ANGLE_BITS-1:0] FRONT_WIDE_LO = 9'd145;
	localparam logic [ANGLE_BITS-1:0] FRONT_WIDE_HI = 9'd215;
	localparam logic [ANGLE_BITS-1:0] BACK_NARROW_LO = 9'd10;
	localparam logic [ANGLE_BITS-1:0] BACK_NARROW_HI = 9'd350;
	localparam logic [ANGLE_BITS-1:0] BACK_WIDE_LO = 9'd35;
	localparam logic [ANGLE_BITS-1:0] BACK_WIDE_HI = 9'd325;
	localparam logic [ANGLE_BITS-1:0] ANGLE_LIMIT = ANGLE_BITS'(SCAN_POINTS);

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle_index;
		logic [DIST_BITS-1:0] distance_mm;
		logic last_sample;
	} sspf_in_t;

	typedef struct packed {
		logic front_rumble;
		logic [INTENS_BITS-1:0] front_intensity;
		logic back_rumble;
		logic [INTENS_BITS-1:0] back_intensity;
	} sspf_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_PREP,
		ST_CHK,
		ST_DIV,
		ST_WR,
		ST_OUT
	} sspf_state_t;

	typedef enum logic {
		DIR_FRONT,
		DIR_BACK
	} sspf_dir_t;

	typedef struct packed {
		logic acc;
		logic sel;
		logic prep;
		logic chk;
		logic step;
		logic wr;
		logic load_out;
		sspf_dir_t dir;
	} sspf_cmd_t;

	typedef struct packed {
		logic out_busy;
	} sspf_stat_t;

endpackage

// File: sv/sspf_ctrl.sv
// Controller of the scan sector proximity feedback block.
// Sequences minimum tracking, the per-direction judge and division, and the
// result load. Depends on sspf_pkg.
module sspf_ctrl
	import sspf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_stall,
	input  logic out_stall,
	input  sspf_stat_t stat,
	output sspf_cmd_t cmd
);

	sspf_state_t state_q, state_d;
	sspf_dir_t dir_q, dir_d;
	logic [STEP_CNT_BITS-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dir_q <= DIR_FRONT;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			dir_q <= dir_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dir_d = dir_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.dir = dir_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (in_last) begin
						dir_d = DIR_FRONT;
						state_d = ST_SEL;
					end
				end
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
					state_d = ST_WR;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_WR: begin
				cmd.wr = 1'b1;
				if (dir_q == DIR_FRONT) begin
					dir_d = DIR_BACK;
					state_d = ST_SEL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// The previous result may still be waiting; load once it leaves.
				if (!stat.out_busy || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/sspf_dp.sv
// Datapath of the scan sector proximity feedback block: configuration
// registers, sector minima, the shared restoring divider and the result register.
// Depends on sspf_pkg; driven by sspf_ctrl commands.
module sspf_dp
	import sspf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIST_BITS-1:0] cfg_data,
	input  sspf_in_t in_data,
	input  sspf_cmd_t cmd,
	output sspf_stat_t stat,
	output logic out_valid,
	input  logic out_stall,
	output sspf_out_t out_data
);

	logic [DIST_BITS-1:0] near_limit_q, side_limit_q, range_min_q;
	logic [DIST_BITS-1:0] fn_min_q, fw_min_q, bn_min_q, bw_min_q;
	logic [INTENS_BITS-1:0] held_front_q, held_back_q;
	logic front_fire_q, back_fire_q;

	logic fire_q, lim_le_q, sat_q;
	logic [DIST_BITS-1:0] limit_q, dsel_q, span_q, diff_q, rem_q;
	logic [INTENS_BITS-1:0] low_q;
	logic out_valid_q;
	sspf_out_t out_q;

	// Sector membership of the incoming sample.
	logic in_range, hit_fn, hit_fw, hit_bn, hit_bw;
	logic [DIST_BITS-1:0] d_in;
	assign d_in = in_data.distance_mm;
	assign in_range = in_data.angle_index < ANGLE_LIMIT;
	assign hit_fn = in_range && in_data.angle_index >= FRONT_NARROW_LO &&
		in_data.angle_index <= FRONT_NARROW_HI;
	assign hit_fw = in_range && in_data.angle_index >= FRONT_WIDE_LO &&
		in_data.angle_index <= FRONT_WIDE_HI;
	assign hit_bn = in_range && (in_data.angle_index <= BACK_NARROW_LO ||
		in_data.angle_index >= BACK_NARROW_HI);
	assign hit_bw = in_range && (in_data.angle_index <= BACK_WIDE_LO ||
		in_data.angle_index >= BACK_WIDE_HI);

	// Choice of the test for the current direction.
	logic [DIST_BITS-1:0] narrow_sel, wide_sel;
	assign narrow_sel = (cmd.dir == DIR_FRONT) ? fn_min_q : bn_min_q;
	assign wide_sel = (cmd.dir == DIR_FRONT) ? fw_min_q : bw_min_q;

	// Dividend is diff * 1023, formed as diff * 1024 - diff.
	logic [DIST_BITS+INTENS_BITS-1:0] dividend;
	assign dividend = {diff_q, {INTENS_BITS{1'b0}}} -
		{{INTENS_BITS{1'b0}}, diff_q};

	logic [DIST_BITS:0] trial;
	logic trial_ge;
	logic [DIST_BITS:0] trial_sub;
	assign trial = {rem_q, low_q[INTENS_BITS-1]};
	assign trial_ge = trial >= {1'b0, span_q};
	assign trial_sub = trial - {1'b0, span_q};

	logic [INTENS_BITS-1:0] new_intens;
	assign new_intens = sat_q ? FULL_INTENSITY : low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit_q <= NEAR_LIMIT_RESET;
			side_limit_q <= SIDE_LIMIT_RESET;
			range_min_q <= RANGE_MIN_RESET;
			fn_min_q <= DIST_ALL_ONES;
			fw_min_q <= DIST_ALL_ONES;
			bn_min_q <= DIST_ALL_ONES;
			bw_min_q <= DIST_ALL_ONES;
			held_front_q <= '0;
			held_back_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NEAR_LIMIT: near_limit_q <= cfg_data;
					CFG_SIDE_LIMIT: side_limit_q <= cfg_data;
					CFG_RANGE_MIN: range_min_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc) begin
				if (hit_fn && d_in < fn_min_q) fn_min_q <= d_in;
				if (hit_fw && d_in < fw_min_q) fw_min_q <= d_in;
				if (hit_bn && d_in < bn_min_q) bn_min_q <= d_in;
				if (hit_bw && d_in < bw_min_q) bw_min_q <= d_in;
			end
			if (cmd.wr && fire_q) begin
				if (cmd.dir == DIR_FRONT) begin
					held_front_q <= new_intens;
				end else begin
					held_back_q <= new_intens;
				end
			end
			if (cmd.load_out) begin
				fn_min_q <= DIST_ALL_ONES;
				fw_min_q <= DIST_ALL_ONES;
				bn_min_q <= DIST_ALL_ONES;
				bw_min_q <= DIST_ALL_ONES;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the judge, divider and result.
	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			if (narrow_sel < near_limit_q) begin
				fire_q <= 1'b1;
				limit_q <= near_limit_q;
				dsel_q <= narrow_sel;
			end else if (wide_sel < side_limit_q) begin
				fire_q <= 1'b1;
				limit_q <= side_limit_q;
				dsel_q <= wide_sel;
			end else begin
				fire_q <= 1'b0;
				limit_q <= side_limit_q;
				dsel_q <= wide_sel;
			end
			if (cmd.dir == DIR_FRONT) begin
				front_fire_q <= (narrow_sel < near_limit_q) || (wide_sel < side_limit_q);
			end else begin
				back_fire_q <= (narrow_sel < near_limit_q) || (wide_sel < side_limit_q);
			end
		end
		if (cmd.prep) begin
			span_q <= limit_q - range_min_q;
			diff_q <= limit_q - dsel_q;
			lim_le_q <= limit_q <= range_min_q;
		end
		if (cmd.chk) begin
			// When the distance is at or below the range minimum the quotient
			// reaches full scale, so the divider result is not needed.
			sat_q <= lim_le_q || (diff_q >= span_q);
			rem_q <= dividend[DIST_BITS+INTENS_BITS-1:INTENS_BITS];
			low_q <= dividend[INTENS_BITS-1:0];
		end
		if (cmd.step) begin
			rem_q <= trial_ge ? trial_sub[DIST_BITS-1:0] : trial[DIST_BITS-1:0];
			low_q <= {low_q[INTENS_BITS-2:0], trial_ge};
		end
		if (cmd.load_out) begin
			out_q.front_rumble <= front_fire_q;
			out_q.front_intensity <= held_front_q;
			out_q.back_rumble <= back_fire_q;
			out_q.back_intensity <= held_back_q;
		end
	end

	assign stat.out_busy = out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: sv/scan_sector_proximity_feedback_top.sv
// After the last sample of a scan is accepted, the block runs a judge and a
// 10-step division pass for the front and then for the back, then loads the
// result. Throughput: one sample per cycle outside that computation; the last
// sample holds off new samples until the result is loaded, which waits while an
// earlier result is still stalled at the output. Reset: arst_n clears minima to all
// ones, held intensities to zero, limits to defaults. Depends on sspf_ctrl, sspf_dp.
module scan_sector_proximity_feedback_top
	import sspf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIST_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  sspf_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output sspf_out_t out_data
);

	sspf_cmd_t cmd;
	sspf_stat_t stat;

	sspf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_last(in_data.last_sample),
		.in_stall(in_stall),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	sspf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.stat(stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

// File: sv/sspf_checker.sv
// Port-level checks for the scan sector proximity feedback block, with the bind
// that attaches them to the top level. Depends on sspf_pkg.
module sspf_checker
	import sspf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  sspf_in_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  sspf_out_t out_data
);

	// A waiting result is held until the transaction completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
	else $error("result changed while stalled");

	// Ending a scan blocks new samples while the result is computed.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last_sample |=> in_stall)
	else $error("sample accepted during result computation");

	// The input side only stalls after a scan-ending transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && in_data.last_sample))
	else $error("input stalled without a scan end");

	// A new result appears only at the end of a computation phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
	else $error("result without a computation phase");

endmodule

bind scan_sector_proximity_feedback_top sspf_checker u_sspf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);

// File: dv/tb_top.sv
// Self-checking testbench for scan_sector_proximity_feedback_top.
// Holds the sector-minimum predictor, the feedback checker and the stimulus tasks.
// Depends on sspf_pkg for the payload structs and the register indexes.
module tb_top;
	import sspf_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
	// Waited after the expected results are back, to leave some margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_SAMPLES = 1200;
	localparam int TIMEOUT_UNITS = 2000000;

	localparam logic [ANGLE_BITS-1:0] FRONT_NARROW_FIRST = 9'd170;
	localparam logic [ANGLE_BITS-1:0] FRONT_NARROW_LAST = 9'd190;
	localparam logic [ANGLE_BITS-1:0] FRONT_WIDE_FIRST = 9'd145;
	localparam logic [ANGLE_BITS-1:0] FRONT_WIDE_LAST = 9'd215;
	localparam logic [ANGLE_BITS-1:0] BACK_NARROW_END = 9'd10;
	localparam logic [ANGLE_BITS-1:0] BACK_NARROW_START = 9'd350;
	localparam logic [ANGLE_BITS-1:0] BACK_WIDE_END = 9'd35;
	localparam logic [ANGLE_BITS-1:0] BACK_WIDE_START = 9'd325;
	localparam logic [ANGLE_BITS-1:0] BEAM_COUNT = 9'd360;

	localparam logic [ANGLE_BITS-1:0] BOUNDARY_BEAMS [18] = '{
		9'd0, 9'd10, 9'd11, 9'd35, 9'd36, 9'd144, 9'd145, 9'd169, 9'd170,
		9'd190, 9'd191, 9'd215, 9'd216, 9'd324, 9'd325, 9'd349, 9'd350, 9'd359
	};

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BLOCKS
	} stall_style_t;

	class feedback_checker;
		logic [DIST_BITS-1:0] near_limit, side_limit, min_range;
		logic [DIST_BITS-1:0] front_narrow, front_wide, back_narrow, back_wide;
		logic [INTENS_BITS-1:0] held_front, held_back;
		sspf_out_t expected_feedback_q[$];
		int unsigned errors, samples, scans, rumbles;

		function new();
			near_limit = 16'd500;
			side_limit = 16'd350;
			min_range = 16'd0;
			held_front = '0;
			held_back = '0;
			errors = 0;
			samples = 0;
			scans = 0;
			rumbles = 0;
			clear_minima();
		endfunction

		function void clear_minima();
			front_narrow = '1;
			front_wide = '1;
			back_narrow = '1;
			back_wide = '1;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIST_BITS-1:0] val);
			case (idx)
			CFG_NEAR_LIMIT: near_limit = val;
			CFG_SIDE_LIMIT: side_limit = val;
			CFG_RANGE_MIN: min_range = val;
			default: ;
			endcase
		endfunction

		// Only called with d below limit, so both differences are positive.
		function logic [INTENS_BITS-1:0] scale(logic [DIST_BITS-1:0] d,
				logic [DIST_BITS-1:0] limit);
			logic [31:0] q;
			if (limit <= min_range)
				return '1;
			q = (32'(limit - d) * 32'd1023) / 32'(limit - min_range);
			if (q > 32'd1023)
				return '1;
			return q[INTENS_BITS-1:0];
		endfunction

		function logic judge(logic [DIST_BITS-1:0] narrow, logic [DIST_BITS-1:0] wide,
				inout logic [INTENS_BITS-1:0] held);
			if (narrow < near_limit) begin
				held = scale(narrow, near_limit);
				return 1'b1;
			end
			if (wide < side_limit) begin
				held = scale(wide, side_limit);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_sample(sspf_in_t s);
			sspf_out_t fb;
			logic [ANGLE_BITS-1:0] a;
			a = s.angle_index;
			samples++;
			if (a < BEAM_COUNT) begin
				if (a >= FRONT_NARROW_FIRST && a <= FRONT_NARROW_LAST
						&& s.distance_mm < front_narrow)
					front_narrow = s.distance_mm;
				if (a >= FRONT_WIDE_FIRST && a <= FRONT_WIDE_LAST
						&& s.distance_mm < front_wide)
					front_wide = s.distance_mm;
				if ((a <= BACK_NARROW_END || a >= BACK_NARROW_START)
						&& s.distance_mm < back_narrow)
					back_narrow = s.distance_mm;
				if ((a <= BACK_WIDE_END || a >= BACK_WIDE_START)
						&& s.distance_mm < back_wide)
					back_wide = s.distance_mm;
			end
			if (!s.last_sample)
				return;
			fb.front_rumble = judge(front_narrow, front_wide, held_front);
			fb.front_intensity = held_front;
			fb.back_rumble = judge(back_narrow, back_wide, held_back);
			fb.back_intensity = held_back;
			expected_feedback_q = {expected_feedback_q, fb};
			clear_minima();
			scans++;
		endfunction

		function void check_feedback(sspf_out_t got);
			sspf_out_t want;
			if (expected_feedback_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: feedback transaction with nothing expected: %s",
						$time, $sformatf("front %0d/%0d back %0d/%0d",
						got.front_rumble, got.front_intensity,
						got.back_rumble, got.back_intensity));
				return;
			end
			want = expected_feedback_q.pop_front();
			if (got.front_rumble !== want.front_rumble
					|| got.front_intensity !== want.front_intensity
					|| got.back_rumble !== want.back_rumble
					|| got.back_intensity !== want.back_intensity) begin
				errors++;
				if (errors <= 10)
					$display("%0t: feedback mismatch: %s, expected %s", $time,
						$sformatf("front %0d/%0d back %0d/%0d",
						got.front_rumble, got.front_intensity,
						got.back_rumble, got.back_intensity),
						$sformatf("front %0d/%0d back %0d/%0d",
						want.front_rumble, want.front_intensity,
						want.back_rumble, want.back_intensity));
			end else if (got.front_rumble || got.back_rumble) begin
				rumbles++;
			end
		endfunction

		function int pending();
			return expected_feedback_q.size();
		endfunction

		function void flag_leftover();
			if (expected_feedback_q.size() > 0) begin
				errors += expected_feedback_q.size();
				$display("%0d expected feedback transactions never arrived",
					expected_feedback_q.size());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [DIST_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	sspf_in_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	sspf_out_t out_data;

	feedback_checker chk = new();

	int burst_left = 0;
	int gap_max = 3;
	int unsigned random_sent = 0;
	int unsigned settings = 0;
	int unsigned sweeps = 0;
	stall_style_t stall_style = STALL_NONE;
	int unsigned stall_cycle = 0;

	scan_sector_proximity_feedback_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("tb_top failed");
		$finish;
	end

	// The receiver stalls the output in one of several randomly chosen styles.
	always @(negedge clk) begin
		if (stall_cycle % 200 == 0)
			stall_style = stall_style_t'($urandom_range(0, 3));
		stall_cycle++;
		case (stall_style)
		STALL_NONE: out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: out_stall <= 1'($urandom_range(0, 1));
		default: out_stall <= (stall_cycle % 16) >= 10;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			chk.check_feedback(out_data);
	end

	task automatic pause_sender(int unsigned cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic push_sample(logic [ANGLE_BITS-1:0] angle, logic [DIST_BITS-1:0] dist_val,
			logic last);
		sspf_in_t s;
		s.angle_index = angle;
		s.distance_mm = dist_val;
		s.last_sample = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0)
				pause_sender($urandom_range(1, gap_max));
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		chk.note_sample(s);
	endtask

	// Holds the sender off until every expected result is back or the wait limit runs out, then lets the block settle.
	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		pause_sender(1);
		while (chk.pending() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIST_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		chk.write_reg(idx, val);
	endtask

	task automatic program_limits(logic [DIST_BITS-1:0] near, logic [DIST_BITS-1:0] side,
			logic [DIST_BITS-1:0] rmin);
		write_reg(CFG_NEAR_LIMIT, near);
		write_reg(CFG_SIDE_LIMIT, side);
		write_reg(CFG_RANGE_MIN, rmin);
		// An index past the register list must leave everything unchanged.
		write_reg(CFG_SPARE, 16'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [DIST_BITS-1:0] pick_level(int unsigned top);
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return 16'($urandom);
		default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	// Distances cluster around the programmed limits so both sides of each test are hit.
	function automatic logic [DIST_BITS-1:0] pick_dist();
		logic [DIST_BITS-1:0] anchor;
		case ($urandom_range(0, 8))
		0: return '0;
		1: return '1;
		2, 3: return 16'($urandom);
		4: anchor = chk.near_limit;
		5: anchor = chk.side_limit;
		6: anchor = chk.min_range;
		default: return 16'($urandom_range(0, 2000));
		endcase
		return anchor + 16'($urandom_range(0, 4)) - 16'd2;
	endfunction

	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		case ($urandom_range(0, 9))
		0, 1, 2: return 9'($urandom_range(145, 215));
		3, 4: return 9'($urandom_range(0, 35));
		5: return 9'($urandom_range(325, 359));
		6, 7: return 9'($urandom_range(0, 359));
		8: return 9'($urandom_range(360, 511));
		default: return BOUNDARY_BEAMS[$urandom_range(0, 17)];
		endcase
	endfunction

	task automatic send_scan(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_sample(pick_angle(), pick_dist(), i == len - 1);
		random_sent += len;
	endtask

	task automatic full_sweep();
		for (int a = 0; a < 360; a++)
			push_sample(9'(a), pick_dist(), a == 359);
		random_sent += 360;
		sweeps++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limits. Out-of-range beams and full-distance samples alone report no rumble.
		push_sample(9'd400, 16'd0, 1'b1);
		push_sample(9'd511, 16'd0, 1'b0);
		push_sample(9'd360, 16'd0, 1'b0);
		push_sample(9'd170, 16'hFFFF, 1'b1);
		push_sample(9'd170, 16'd0, 1'b0);
		push_sample(9'd359, 16'd499, 1'b1);
		push_sample(9'd190, 16'd500, 1'b0);
		push_sample(9'd215, 16'd349, 1'b0);
		push_sample(9'd0, 16'd350, 1'b0);
		push_sample(9'd35, 16'd0, 1'b1);
		// Beams just outside each sector, then only the wide back sector.
		push_sample(9'd144, 16'd0, 1'b0);
		push_sample(9'd216, 16'd0, 1'b0);
		push_sample(9'd36, 16'd0, 1'b0);
		push_sample(9'd324, 16'd0, 1'b0);
		push_sample(9'd11, 16'd300, 1'b1);
		push_sample(9'd169, 16'd100, 1'b0);
		push_sample(9'd191, 16'd0, 1'b0);
		push_sample(9'd10, 16'hFFFF, 1'b0);
		push_sample(9'd350, 16'hFFFF, 1'b1);
		drain_results();

		// Zero limits never fire; the held intensities repeat.
		program_limits(16'd0, 16'd0, 16'd0);
		push_sample(9'd180, 16'd0, 1'b0);
		push_sample(9'd5, 16'd0, 1'b1);
		drain_results();

		// Limits not above the range minimum give full intensity when they fire.
		program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_sample(9'd180, 16'hFFFE, 1'b0);
		push_sample(9'd5, 16'd0, 1'b1);
		drain_results();

		// Distances under the range minimum saturate.
		program_limits(16'd1000, 16'd600, 16'd200);
		push_sample(9'd180, 16'd50, 1'b0);
		push_sample(9'd340, 16'd100, 1'b1);
		push_sample(9'd185, 16'd999, 1'b1);

		while (random_sent < RANDOM_SAMPLES) begin
			drain_results();
			program_limits(pick_level(3000), pick_level(3000), pick_level(400));
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat ($urandom_range(2, 8)) begin
				if (sweeps == 0 || $urandom_range(0, 59) == 0)
					full_sweep();
				else
					send_scan($urandom_range(1, 30));
				if ($urandom_range(0, 7) == 0)
					drain_results();
			end
		end
		drain_results();
		chk.flag_leftover();

		$display("Covered %0d samples in %0d scans (%0d full sweeps) over %0d settings;",
			chk.samples, chk.scans, sweeps, settings);
		$display("%0d feedback transactions carried a rumble.", chk.rumbles);
		if (chk.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// File: filelist.f
sv/sspf_pkg.sv
sv/sspf_ctrl.sv
sv/sspf_dp.sv
sv/scan_sector_proximity_feedback_top.sv
sv/sspf_checker.sv
dv/tb_top.sv
